// ===== src/sha256_streaming_hash_defines.svh =====
// Assertion macros for the streaming SHA-256 block.
// Used by the checker; no other dependencies.
`ifndef SHA256_STREAMING_HASH_DEFINES_SVH
`define SHA256_STREAMING_HASH_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SHA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same form, for properties that must also hold during reset
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sha_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 block.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

   typedef logic [7:0][31:0] words8_type;

   // Control from the sequencer to the round datapath
   typedef struct packed {
      logic        init;
      logic        load_en;
      logic [31:0] load_word;
      logic        round_en;
      logic [5:0]  round;
   } core_ctrl_type;

   // Initial hash values, index 0 in the low slot
   localparam words8_type IV_WORDS = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction

   // Round constants
   function automatic logic [31:0] round_const(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// ===== src/sha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sha_core.sv =====
// Round datapath: working variables and the 16-word message schedule window.
// Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_core (
   input  logic                   clock,
   input  sha_pkg::core_ctrl_type ctrl,
   input  sha_pkg::words8_type    hash_words,
   output sha_pkg::words8_type    work_words
);
   import sha_pkg::*;

   words8_type  v_ff, v_in;
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] t1, t2, ch, mj, w_new;

   // One compression round and the schedule extension
   always_comb begin
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      mj    = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1    = v_ff[7] + big_sigma1(v_ff[4]) + ch + round_const(ctrl.round) + win_ff[0];
      t2    = big_sigma0(v_ff[0]) + mj;
      w_new = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9] + small_sigma1(win_ff[14]);

      v_in = v_ff;
      if (ctrl.init) begin
         v_in = hash_words;
      end else if (ctrl.round_en) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end

      // window shifts down; the newest word enters at the top
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctrl.load_en || ctrl.round_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = ctrl.load_en ? ctrl.load_word : w_new;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      for (int i = 0; i < 16; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   assign work_words = v_ff;

endmodule

// ===== src/sha256_streaming_hash.sv =====
// Append: bytes are taken only while idle; each 64th byte starts a compression
// (loading the chunk RAM, 64 rounds, 1 fold) during which no byte is taken.
// Finish: one compression, or two when fewer than 8 bytes remain after 0x80,
// then 8 digest words at one per cycle while rsp_ready is high.
// One request at a time. Synchronous active-high reset loads the initial hash
// and clears the byte counts; the chunk RAM needs no clearing.
`timescale 1ns / 1ps

module sha256_streaming_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_FOLD, S_EMIT} state_type;
   typedef enum logic [1:0] {KIND_DATA, KIND_PAD, KIND_LEN} kind_type;

   state_type     state_ff;
   kind_type      kind_ff;
   logic [5:0]    cnt_ff;
   logic [5:0]    fill_ff;
   logic [60:0]   count_ff;
   logic [23:0]   wbuf_ff;
   logic [2:0]    idx_ff;
   words8_type    h_ff;
   words8_type    work_words;
   core_ctrl_type ctrl;

   logic          accept;
   logic          ram_wr_en;
   logic [31:0]   ram_wr_data;
   logic [31:0]   ram_rd_data;
   logic [3:0]    load_idx;
   logic [31:0]   part_word;
   logic [31:0]   load_word;
   logic [63:0]   len_bits;
   logic          pad_has_len;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Byte packing: every fourth byte writes a whole word
   assign ram_wr_en   = accept && !req_mode && (fill_ff[1:0] == 2'd3);
   assign ram_wr_data = {wbuf_ff, req_data_byte};

   sha_ram #(.WIDTH(32), .DEPTH(16)) u_chunk_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (fill_ff[5:2]),
      .wr_data (ram_wr_data),
      .rd_addr (cnt_ff[3:0]),
      .rd_data (ram_rd_data)
   );

   // Padded word assembly for finish chunks
   assign load_idx    = cnt_ff[3:0] - 4'd1;
   assign len_bits    = {count_ff, 3'b000};
   assign pad_has_len = (fill_ff[5:3] != 3'b111);

   always_comb begin
      case (fill_ff[1:0])
         2'd0:    part_word = 32'h8000_0000;
         2'd1:    part_word = {wbuf_ff[7:0], 8'h80, 16'h0000};
         2'd2:    part_word = {wbuf_ff[15:0], 8'h80, 8'h00};
         default: part_word = {wbuf_ff[23:0], 8'h80};
      endcase

      load_word = ram_rd_data;
      if (kind_ff != KIND_DATA) begin
         if (kind_ff == KIND_PAD && load_idx < fill_ff[5:2]) begin
            load_word = ram_rd_data;
         end else if (kind_ff == KIND_PAD && load_idx == fill_ff[5:2]) begin
            load_word = part_word;
         end else begin
            load_word = 32'h0;
         end
         if (kind_ff == KIND_LEN || pad_has_len) begin
            if (load_idx == 4'd14) begin
               load_word = len_bits[63:32];
            end else if (load_idx == 4'd15) begin
               load_word = len_bits[31:0];
            end
         end
      end
   end

   // Datapath control
   always_comb begin
      ctrl.init      = (state_ff == S_LOAD) && (cnt_ff == 6'd0);
      ctrl.load_en   = (state_ff == S_LOAD) && (cnt_ff != 6'd0);
      ctrl.load_word = load_word;
      ctrl.round_en  = (state_ff == S_ROUND);
      ctrl.round     = cnt_ff;
   end

   sha_core u_core (
      .clock      (clock),
      .ctrl       (ctrl),
      .hash_words (h_ff),
      .work_words (work_words)
   );

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_DATA;
         cnt_ff   <= 6'd0;
         fill_ff  <= 6'd0;
         count_ff <= 61'd0;
         idx_ff   <= 3'd0;
         h_ff     <= IV_WORDS;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cnt_ff <= 6'd0;
                  if (!req_mode) begin
                     wbuf_ff  <= {wbuf_ff[15:0], req_data_byte};
                     fill_ff  <= fill_ff + 6'd1;
                     count_ff <= count_ff + 61'd1;
                     if (fill_ff == 6'd63) begin
                        kind_ff  <= KIND_DATA;
                        state_ff <= S_LOAD;
                     end
                  end else begin
                     kind_ff  <= KIND_PAD;
                     state_ff <= S_LOAD;
                  end
               end
            end
            S_LOAD: begin
               if (cnt_ff == 6'd16) begin
                  cnt_ff   <= 6'd0;
                  state_ff <= S_ROUND;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_ROUND: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= S_FOLD;
               end
            end
            S_FOLD: begin
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= h_ff[i] + work_words[i];
               end
               cnt_ff <= 6'd0;
               idx_ff <= 3'd0;
               if (kind_ff == KIND_DATA) begin
                  state_ff <= S_IDLE;
               end else if (kind_ff == KIND_PAD && !pad_has_len) begin
                  kind_ff  <= KIND_LEN;
                  state_ff <= S_LOAD;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (rsp_ready) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     h_ff     <= IV_WORDS;
                     fill_ff  <= 6'd0;
                     count_ff <= 61'd0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = (state_ff == S_EMIT);
   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

endmodule

// ===== src/sha_checker.sv =====
// Port-level checks for the streaming SHA-256 block, bound to the top level.
// Depends on sha256_streaming_hash_defines.svh.
`timescale 1ns / 1ps
`include "sha256_streaming_hash_defines.svh"

module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // a waiting request holds its payload
   `SHA_ASSERT(a_req_hold, clock, reset, req_valid && !req_ready |=> req_valid && $stable(req_mode) && $stable(req_data_byte), "waiting request changed")

   // a stalled digest word holds
   `SHA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index), "stalled digest word changed")

   // no request taken while the digest is going out
   `SHA_ASSERT(a_no_req_in_emit, clock, reset, rsp_valid |-> !req_ready, "request accepted during digest output")

   // last flag only on word seven
   `SHA_ASSERT(a_last_idx, clock, reset, rsp_last_word == (rsp_word_index == 3'd7), "last flag and word index disagree")

   // words go out in order without gaps
   `SHA_ASSERT(a_idx_step, clock, reset, rsp_valid && rsp_ready && !rsp_last_word |=> rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1, "digest word skipped")

endmodule

bind sha256_streaming_hash sha_checker u_sha_checker (.*);
